### rtl/hcb_pkg.sv
package hcb_pkg;

   localparam int SYMBOL_COUNT  = 256;
   localparam int NODE_COUNT    = 2 * SYMBOL_COUNT - 1;
   localparam int SYM_W         = 8;
   localparam int NODE_W        = 9;
   localparam int COUNT_BITS    = 32;
   localparam int MAX_CODE_BITS = 64;
   localparam int LEN_W         = 7;
   localparam int DEPTH_W       = 8;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [1:0] CMD_COUNT  = 2'd0;
   localparam logic [1:0] CMD_BUILD  = 2'd1;
   localparam logic [1:0] CMD_ENCODE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TOO_LONG = 2'd1;
   localparam logic [1:0] ST_REJECT   = 2'd2;

   // weight store access
   typedef struct packed {
      logic [NODE_W-1:0]     rd_addr;
      logic                  we;
      logic [NODE_W-1:0]     wr_addr;
      logic [COUNT_BITS-1:0] wr_data;
   } wport_type;

   // code table write
   typedef struct packed {
      logic                     we;
      logic [SYM_W-1:0]         addr;
      logic [MAX_CODE_BITS-1:0] word;
      logic [LEN_W-1:0]         size;
   } cwrite_type;

   typedef struct packed {
      logic done;
      logic too_long;
   } bstat_type;

endpackage

### rtl/hcb_weight_store.sv
module hcb_weight_store
   import hcb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  wport_type             port,
   output logic [COUNT_BITS-1:0] rd_data
);

   logic [COUNT_BITS-1:0]   mem [NODE_COUNT];
   logic [SYMBOL_COUNT-1:0] leaf_valid_ff;
   logic [COUNT_BITS-1:0]   rd_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (port.we) begin
         mem[port.wr_addr] <= port.wr_data;
      end
      rd_ff <= mem[port.rd_addr];
   end

   // leaves read as zero until written since the last clear
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         leaf_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (port.we && !port.wr_addr[NODE_W-1]) begin
            leaf_valid_ff[port.wr_addr[SYM_W-1:0]] <= 1'b1;
         end
         rd_valid_ff <= port.rd_addr[NODE_W-1] | leaf_valid_ff[port.rd_addr[SYM_W-1:0]];
      end
   end

   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule

### rtl/hcb_code_table.sv
module hcb_code_table
   import hcb_pkg::*;
(
   input  logic                     clock,
   input  cwrite_type               wr,
   input  logic [SYM_W-1:0]         rd_addr,
   output logic [MAX_CODE_BITS-1:0] rd_word,
   output logic [LEN_W-1:0]         rd_size
);

   logic [MAX_CODE_BITS+LEN_W-1:0] mem [SYMBOL_COUNT];
   logic [MAX_CODE_BITS+LEN_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= {wr.word, wr.size};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_word = rd_ff[MAX_CODE_BITS+LEN_W-1:LEN_W];
   assign rd_size = rd_ff[LEN_W-1:0];

endmodule

### rtl/hcb_tree_builder.sv
module hcb_tree_builder
   import hcb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COUNT_BITS-1:0] w_rdata,
   output wport_type             wport,
   output cwrite_type            cwrite,
   output bstat_type             stat
);

   localparam logic [2:0] B_IDLE   = 3'd0;
   localparam logic [2:0] B_SWEEP  = 3'd1;
   localparam logic [2:0] B_SCAN   = 3'd2;
   localparam logic [2:0] B_MERGE1 = 3'd3;
   localparam logic [2:0] B_MERGE2 = 3'd4;
   localparam logic [2:0] B_WSTART = 3'd5;
   localparam logic [2:0] B_WSTEP  = 3'd6;

   localparam logic [NODE_W-1:0] LAST_NODE  = NODE_W'(NODE_COUNT - 1);
   localparam logic [NODE_W-1:0] FIRST_NODE = NODE_W'(SYMBOL_COUNT);
   localparam logic [SYM_W-1:0]  LAST_SYM   = SYM_W'(SYMBOL_COUNT - 1);

   // parent entry: {parent index, branch bit}, parent zero means none
   logic [NODE_W:0] pmem [NODE_COUNT];
   logic [NODE_W:0] p_rdata;
   logic [NODE_W-1:0] p_raddr;
   logic              p_we;
   logic [NODE_W-1:0] p_waddr;
   logic [NODE_W:0]   p_wdata;

   logic [2:0]                state_ff, state_in;
   logic [NODE_W-1:0]         cnt_ff, cnt_in;       // sweep index / scan issue index
   logic [NODE_W-1:0]         node_ff, node_in;     // node being formed
   logic                      dv_ff, dv_in;
   logic [NODE_W-1:0]         didx_ff, didx_in;
   logic                      has1_ff, has1_in, has2_ff, has2_in;
   logic [NODE_W-1:0]         idx1_ff, idx1_in, idx2_ff, idx2_in;
   logic [COUNT_BITS-1:0]     w1_ff, w1_in, w2_ff, w2_in;
   logic [SYM_W-1:0]          sym_ff, sym_in;
   logic [DEPTH_W-1:0]        len_ff, len_in;
   logic [MAX_CODE_BITS-1:0]  code_ff, code_in;
   logic                      long_ff, long_in;
   logic [COUNT_BITS:0]       sum;
   logic [NODE_W-1:0]         up;

   always_ff @(posedge clock) begin
      if (p_we) begin
         pmem[p_waddr] <= p_wdata;
      end
      p_rdata <= pmem[p_raddr];
   end

   assign sum = {1'b0, w1_ff} + {1'b0, w2_ff};
   assign up  = p_rdata[NODE_W:1];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      node_in  = node_ff;
      dv_in    = 1'b0;
      didx_in  = cnt_ff;
      has1_in  = has1_ff;
      has2_in  = has2_ff;
      idx1_in  = idx1_ff;
      idx2_in  = idx2_ff;
      w1_in    = w1_ff;
      w2_in    = w2_ff;
      sym_in   = sym_ff;
      len_in   = len_ff;
      code_in  = code_ff;
      long_in  = long_ff;
      p_raddr  = cnt_ff;
      p_we     = 1'b0;
      p_waddr  = cnt_ff;
      p_wdata  = '0;
      wport    = '{rd_addr: cnt_ff, we: 1'b0, wr_addr: node_ff, wr_data: '0};
      cwrite   = '{we: 1'b0, addr: sym_ff, word: code_ff, size: len_ff[LEN_W-1:0]};
      stat     = '{done: 1'b0, too_long: 1'b0};
      unique case (state_ff)
         B_IDLE: begin
            if (start) begin
               cnt_in   = '0;
               long_in  = 1'b0;
               state_in = B_SWEEP;
            end
         end
         B_SWEEP: begin
            p_we = 1'b1;
            if (cnt_ff == LAST_NODE) begin
               node_in  = FIRST_NODE;
               cnt_in   = '0;
               has1_in  = 1'b0;
               has2_in  = 1'b0;
               state_in = B_SCAN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         B_SCAN: begin
            if (cnt_ff < node_ff) begin
               dv_in  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            // keep the two lightest parentless nodes, earlier index wins ties
            if (dv_ff && up == '0) begin
               if (!has1_ff || w_rdata < w1_ff) begin
                  has2_in = has1_ff;
                  idx2_in = idx1_ff;
                  w2_in   = w1_ff;
                  has1_in = 1'b1;
                  idx1_in = didx_ff;
                  w1_in   = w_rdata;
               end else if (!has2_ff || w_rdata < w2_ff) begin
                  has2_in = 1'b1;
                  idx2_in = didx_ff;
                  w2_in   = w_rdata;
               end
            end
            if (dv_ff && didx_ff == node_ff - 1'b1) begin
               state_in = B_MERGE1;
            end
         end
         B_MERGE1: begin
            p_we          = 1'b1;
            p_waddr       = idx1_ff;
            p_wdata       = {node_ff, 1'b1};
            wport.we      = 1'b1;
            wport.wr_data = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
            state_in      = B_MERGE2;
         end
         B_MERGE2: begin
            p_we    = 1'b1;
            p_waddr = idx2_ff;
            p_wdata = {node_ff, 1'b0};
            if (node_ff == LAST_NODE) begin
               sym_in   = '0;
               state_in = B_WSTART;
            end else begin
               node_in  = node_ff + 1'b1;
               cnt_in   = '0;
               has1_in  = 1'b0;
               has2_in  = 1'b0;
               state_in = B_SCAN;
            end
         end
         B_WSTART: begin
            p_raddr  = {1'b0, sym_ff};
            len_in   = '0;
            code_in  = '0;
            state_in = B_WSTEP;
         end
         B_WSTEP: begin
            if (up == '0) begin
               cwrite.we = 1'b1;
               if (len_ff > DEPTH_W'(MAX_CODE_BITS)) begin
                  cwrite.word = '0;
                  cwrite.size = '0;
                  long_in     = 1'b1;
               end
               len_in  = '0;
               code_in = '0;
               if (sym_ff == LAST_SYM) begin
                  stat.done     = 1'b1;
                  stat.too_long = long_in;
                  state_in      = B_IDLE;
               end else begin
                  sym_in  = sym_ff + 1'b1;
                  p_raddr = {1'b0, sym_in};
               end
            end else begin
               if (len_ff < DEPTH_W'(MAX_CODE_BITS)) begin
                  code_in = code_ff |
                     (MAX_CODE_BITS'(p_rdata[0]) << len_ff[$clog2(MAX_CODE_BITS)-1:0]);
               end
               len_in  = len_ff + 1'b1;
               p_raddr = up;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dv_ff    <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      node_ff <= node_in;
      didx_ff <= didx_in;
      has1_ff <= has1_in;
      has2_ff <= has2_in;
      idx1_ff <= idx1_in;
      idx2_ff <= idx2_in;
      w1_ff   <= w1_in;
      w2_ff   <= w2_in;
      sym_ff  <= sym_in;
      len_ff  <= len_in;
      code_ff <= code_in;
      long_ff <= long_in;
   end

endmodule

### rtl/huffman_code_builder_encoder.sv
// channel | direction | handshake           | payload
// req_    | in        | req_valid/req_stall | req_command, req_data_byte
// rsp_    | out       | rsp_valid/rsp_stall | rsp_code_bits, rsp_code_length, rsp_status
//
// Count and encode read a store, then write back or look up the code; reject and clear answer from idle.
// Build is bound by the single read port of the node stores: a scan per merge, a walk to the root per symbol.
// Reset is synchronous; counts read as zero after reset and clear.
// A stalled result sits in the output register; a following result waits in a
// hold register and new items are taken once it has moved out.
module huffman_code_builder_encoder
   import hcb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_command,
   input  logic [7:0]               req_data_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [63:0]              rsp_code_bits,
   output logic [6:0]               rsp_code_length,
   output logic [1:0]               rsp_status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CNT   = 3'd1;
   localparam logic [2:0] S_ENC   = 3'd2;
   localparam logic [2:0] S_BUILD = 3'd3;
   localparam logic [2:0] S_HOLD  = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic                     ready_ff, ready_in;
   logic [SYM_W-1:0]         sym_ff;
   logic                     out_v_ff, out_v_in;
   logic [MAX_CODE_BITS-1:0] out_bits_ff, hold_bits_ff;
   logic [LEN_W-1:0]         out_len_ff, hold_len_ff;
   logic [1:0]               out_st_ff, hold_st_ff;

   logic                     accept, out_free;
   logic                     fin, start, clear;
   logic [MAX_CODE_BITS-1:0] fin_bits;
   logic [LEN_W-1:0]         fin_len;
   logic [1:0]               fin_st;
   logic                     load_out, load_hold;

   logic [COUNT_BITS-1:0]    w_rdata;
   wport_type                wport, bld_wport;
   cwrite_type               cwrite;
   bstat_type                bstat;
   logic [MAX_CODE_BITS-1:0] c_word;
   logic [LEN_W-1:0]         c_size;

   hcb_weight_store u_weights (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .port    (wport),
      .rd_data (w_rdata)
   );

   hcb_tree_builder u_builder (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .w_rdata (w_rdata),
      .wport   (bld_wport),
      .cwrite  (cwrite),
      .stat    (bstat)
   );

   hcb_code_table u_codes (
      .clock   (clock),
      .wr      (cwrite),
      .rd_addr (req_data_byte),
      .rd_word (c_word),
      .rd_size (c_size)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_v_ff || !rsp_stall;

   always_comb begin
      wport = bld_wport;
      if (state_ff == S_IDLE) begin
         wport.rd_addr = {1'b0, req_data_byte};
         wport.we      = 1'b0;
      end else if (state_ff == S_CNT) begin
         wport.we      = (w_rdata != COUNT_MAX);
         wport.wr_addr = {1'b0, sym_ff};
         wport.wr_data = w_rdata + 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ready_in  = ready_ff;
      fin       = 1'b0;
      fin_bits  = '0;
      fin_len   = '0;
      fin_st    = ST_OK;
      start     = 1'b0;
      clear     = 1'b0;
      load_out  = 1'b0;
      load_hold = 1'b0;
      out_v_in  = out_v_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_COUNT: begin
                     if (ready_ff) begin
                        fin    = 1'b1;
                        fin_st = ST_REJECT;
                     end else begin
                        state_in = S_CNT;
                     end
                  end
                  CMD_BUILD: begin
                     start    = 1'b1;
                     state_in = S_BUILD;
                  end
                  CMD_ENCODE: begin
                     if (!ready_ff) begin
                        fin    = 1'b1;
                        fin_st = ST_REJECT;
                     end else begin
                        state_in = S_ENC;
                     end
                  end
                  CMD_CLEAR: begin
                     clear    = 1'b1;
                     ready_in = 1'b0;
                     fin      = 1'b1;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CNT: fin = 1'b1;
         S_ENC: begin
            fin = 1'b1;
            if (c_size == '0) begin
               fin_st = ST_TOO_LONG;
            end else begin
               fin_bits = c_word;
               fin_len  = c_size;
            end
         end
         S_BUILD: begin
            if (bstat.done) begin
               fin      = 1'b1;
               ready_in = 1'b1;
               fin_st   = bstat.too_long ? ST_TOO_LONG : ST_OK;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (fin) begin
         if (out_free) begin
            load_out = 1'b1;
            state_in = S_IDLE;
         end else begin
            load_hold = 1'b1;
            state_in  = S_HOLD;
         end
      end
      if (load_out) begin
         out_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sym_ff <= req_data_byte;
      end
      if (load_hold) begin
         hold_bits_ff <= fin_bits;
         hold_len_ff  <= fin_len;
         hold_st_ff   <= fin_st;
      end
      if (load_out) begin
         out_bits_ff <= (state_ff == S_HOLD) ? hold_bits_ff : fin_bits;
         out_len_ff  <= (state_ff == S_HOLD) ? hold_len_ff : fin_len;
         out_st_ff   <= (state_ff == S_HOLD) ? hold_st_ff : fin_st;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_code_bits   = out_bits_ff;
   assign rsp_code_length = out_len_ff;
   assign rsp_status      = out_st_ff;

`ifndef SYNTHESIS
   a_done_in_build: assert property (@(posedge clock) disable iff (reset)
      bstat.done |-> state_ff == S_BUILD)
      else $error("tree build finished outside build");

   a_encode_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ENC |-> ready_ff)
      else $error("encode lookup before codes were built");

   a_len_ok: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_len_ff != '0 |-> out_st_ff == ST_OK)
      else $error("code length given with error status");
`endif

endmodule
